[hw/rtl/svq_pkg.sv]
// Shared types, constants and helpers for the sprite quad vertex setup block.
// Used by svq_cordic, svq_div and sprite_quad_vertex_setup.
package svq_pkg;

  localparam int COORD_FRAC_BITS = 4;
  localparam int ANGLE_BITS      = 16;

  localparam int CORDIC_STEPS  = 24;
  localparam int CORDIC_STAGES = CORDIC_STEPS / 2;
  localparam int CORDIC_LAT    = CORDIC_STAGES + 1;
  localparam int CW            = 34;
  localparam int ZW            = 32;

  localparam logic signed [CW-1:0] CORDIC_GAIN_INV = CW'(652032874);
  localparam logic signed [CW-1:0] ONE_Q30         = CW'(1073741824);

  localparam logic [29:0] ATAN_TURN [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

  localparam int QW         = 16;
  localparam int DEN_W      = 14;
  localparam int NUM_W      = 32;
  localparam int DIV_STAGES = QW / 2;
  localparam int DIV_LAT    = DIV_STAGES + 1;

  localparam int VP_SHIFT  = 16 + COORD_FRAC_BITS;
  localparam int TEX_NUM_W = 17 + 14 - COORD_FRAC_BITS + 1;
  localparam int CXQ_W     = 18;
  localparam int PROD_W    = CW + 17;
  localparam int P_W       = 52;

  localparam logic [QW-1:0] NDC_X_FLIP = 16'h8000;
  localparam logic [QW-1:0] NDC_Y_FLIP = 16'h7FFF;

  localparam int VERTS = 6;
  localparam logic [2:0] LAST_IDX = 3'(VERTS - 1);

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEWPORT_WIDTH  = 3'd0,
    REG_VIEWPORT_HEIGHT = 3'd1,
    REG_TEXTURE_WIDTH   = 3'd2,
    REG_TEXTURE_HEIGHT  = 3'd3
  } cfg_reg_e;

  localparam logic [DEN_W-1:0] VIEWPORT_WIDTH_RST  = 14'd1280;
  localparam logic [DEN_W-1:0] VIEWPORT_HEIGHT_RST = 14'd720;
  localparam logic [DEN_W-1:0] TEXTURE_WIDTH_RST   = 14'd256;
  localparam logic [DEN_W-1:0] TEXTURE_HEIGHT_RST  = 14'd256;

  typedef struct packed {
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic [15:0]        dest_w;
    logic [15:0]        dest_h;
    logic [31:0]        tint_rgba;
    logic [15:0]        turn;
    logic [15:0]        src_x;
    logic [15:0]        src_y;
    logic [15:0]        src_w;
    logic [15:0]        src_h;
  } sprite_t;

  typedef struct packed {
    logic signed [15:0] ndc_x;
    logic signed [15:0] ndc_y;
    logic [31:0]        vertex_rgba;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic               last_vertex;
  } vertex_t;

  function automatic logic [1:0] corner_of(logic [2:0] idx);
    logic [1:0] c;
    unique case (idx)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd2;
      3'd4:    c = 2'd1;
      3'd5:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/sprite_quad_vertex_setup.sv]
// Rotated sprite quad vertex setup: one sprite in, six vertices out.
// Instantiates svq_cordic and svq_div; types and constants from svq_pkg.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  sprite   | start / busy               | sprite (sprite_t)
//  vertex   | vertex_strobe, no backpr.  | vertex (vertex_t)
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// After each transfer, busy spaces sprites to suit the one-vertex-per-cycle
// result port; new sprites enter while earlier ones are in the pipeline. A
// sprite passes sprite register, CORDIC, multiply, sum and round registers,
// divider, hold and output registers before its first vertex strobes. Six
// vertices follow on consecutive cycles. rst is synchronous; it clears all
// valid bits, loads reset values and holds busy high. No vertex-side stall.
module sprite_quad_vertex_setup (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  svq_pkg::sprite_t                  sprite,
  output logic                              vertex_strobe,
  output svq_pkg::vertex_t                  vertex,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [svq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [svq_pkg::DEN_W-1:0]         cfg_data
);

  typedef struct packed {
    logic signed [svq_pkg::CXQ_W-1:0] cxq;
    logic signed [svq_pkg::CXQ_W-1:0] cyq;
    logic [15:0]                      w;
    logic [15:0]                      h;
    logic [31:0]                      rgba;
    logic [svq_pkg::TEX_NUM_W-1:0]    tu0;
    logic [svq_pkg::TEX_NUM_W-1:0]    tu1;
    logic [svq_pkg::TEX_NUM_W-1:0]    tv0;
    logic [svq_pkg::TEX_NUM_W-1:0]    tv1;
  } pl_t;

  localparam int CL = svq_pkg::CORDIC_LAT;
  localparam int DL = svq_pkg::DIV_LAT;
  localparam int TSH = 14 - svq_pkg::COORD_FRAC_BITS;

  logic [svq_pkg::DEN_W-1:0] viewport_w;
  logic [svq_pkg::DEN_W-1:0] viewport_h;
  logic [svq_pkg::DEN_W-1:0] texture_w;
  logic [svq_pkg::DEN_W-1:0] texture_h;
  logic [svq_pkg::DEN_W-1:0] cfg_value;

  logic [2:0]       gap;
  logic             accept;
  logic             v0;
  svq_pkg::sprite_t sp;
  pl_t              pl_in;
  logic [16:0]      su1;
  logic [16:0]      sv1;

  pl_t  pd [CL];
  logic vd [CL];

  logic signed [svq_pkg::CW-1:0] cos_q;
  logic signed [svq_pkg::CW-1:0] sin_q;

  pl_t                               m_pl;
  logic                              vm;
  logic signed [svq_pkg::PROD_W-1:0] prod_cw;
  logic signed [svq_pkg::PROD_W-1:0] prod_sh;
  logic signed [svq_pkg::PROD_W-1:0] prod_sw;
  logic signed [svq_pkg::PROD_W-1:0] prod_ch;

  pl_t                            s_pl;
  logic                           vs;
  logic signed [svq_pkg::P_W-1:0] bx;
  logic signed [svq_pkg::P_W-1:0] by;
  logic signed [svq_pkg::P_W-1:0] ea;
  logic signed [svq_pkg::P_W-1:0] eb;
  logic signed [svq_pkg::P_W-1:0] ec;
  logic signed [svq_pkg::P_W-1:0] ed;
  logic signed [svq_pkg::P_W-1:0] px [4];
  logic signed [svq_pkg::P_W-1:0] py [4];
  logic signed [svq_pkg::P_W-1:0] offx;
  logic signed [svq_pkg::P_W-1:0] offy;

  pl_t                              n_pl;
  logic                             vn;
  logic signed [svq_pkg::NUM_W-1:0] nx [4];
  logic signed [svq_pkg::NUM_W-1:0] ny [4];

  logic [svq_pkg::QW-1:0] qx [4];
  logic [svq_pkg::QW-1:0] qy [4];
  logic [svq_pkg::QW-1:0] qu0;
  logic [svq_pkg::QW-1:0] qu1;
  logic [svq_pkg::QW-1:0] qv0;
  logic [svq_pkg::QW-1:0] qv1;

  logic [31:0] rd [DL];
  logic        rv [DL];
  logic        load;

  logic [svq_pkg::QW-1:0] hx [4];
  logic [svq_pkg::QW-1:0] hy [4];
  logic [svq_pkg::QW-1:0] hu0;
  logic [svq_pkg::QW-1:0] hu1;
  logic [svq_pkg::QW-1:0] hv0;
  logic [svq_pkg::QW-1:0] hv1;
  logic [31:0]            hrgba;

  logic             active;
  logic [2:0]       idx;
  logic [1:0]       corner;
  svq_pkg::vertex_t cur;

  // configuration
  assign cfg_ready = 1'b1;
  assign cfg_value = (cfg_data == '0) ? svq_pkg::DEN_W'(1) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      viewport_w <= svq_pkg::VIEWPORT_WIDTH_RST;
      viewport_h <= svq_pkg::VIEWPORT_HEIGHT_RST;
      texture_w  <= svq_pkg::TEXTURE_WIDTH_RST;
      texture_h  <= svq_pkg::TEXTURE_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (svq_pkg::cfg_reg_e'(cfg_index))
        svq_pkg::REG_VIEWPORT_WIDTH:  viewport_w <= cfg_value;
        svq_pkg::REG_VIEWPORT_HEIGHT: viewport_h <= cfg_value;
        svq_pkg::REG_TEXTURE_WIDTH:   texture_w  <= cfg_value;
        svq_pkg::REG_TEXTURE_HEIGHT:  texture_h  <= cfg_value;
        default: ;
      endcase
    end
  end

  // intake spacing
  assign busy   = rst || (gap != 3'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= '0;
      v0  <= 1'b0;
    end else begin
      v0 <= accept;
      if (accept) begin
        gap <= svq_pkg::LAST_IDX;
      end else if (busy) begin
        gap <= gap - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sp <= sprite;
    end
  end

  always_comb begin
    su1        = 17'(sp.src_x) + 17'(sp.src_w);
    sv1        = 17'(sp.src_y) + 17'(sp.src_h);
    pl_in.cxq  = $signed({sp.dest_x[15], sp.dest_x, 1'b0}) + $signed({2'b00, sp.dest_w});
    pl_in.cyq  = $signed({sp.dest_y[15], sp.dest_y, 1'b0}) + $signed({2'b00, sp.dest_h});
    pl_in.w    = sp.dest_w;
    pl_in.h    = sp.dest_h;
    pl_in.rgba = sp.tint_rgba;
    pl_in.tu0  = (svq_pkg::TEX_NUM_W'(sp.src_x) << TSH) +
                 svq_pkg::TEX_NUM_W'(texture_w >> 1);
    pl_in.tu1  = (svq_pkg::TEX_NUM_W'(su1) << TSH) +
                 svq_pkg::TEX_NUM_W'(texture_w >> 1);
    pl_in.tv0  = (svq_pkg::TEX_NUM_W'(sp.src_y) << TSH) +
                 svq_pkg::TEX_NUM_W'(texture_h >> 1);
    pl_in.tv1  = (svq_pkg::TEX_NUM_W'(sv1) << TSH) +
                 svq_pkg::TEX_NUM_W'(texture_h >> 1);
  end

  // angle to cos/sin, payload travels alongside
  svq_cordic u_cordic (
    .clk   (clk),
    .turn  (sp.turn),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  always_ff @(posedge clk) begin
    pd[0] <= pl_in;
    for (int i = 1; i < CL; i++) begin
      pd[i] <= pd[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CL; i++) begin
        vd[i] <= 1'b0;
      end
    end else begin
      vd[0] <= v0;
      for (int i = 1; i < CL; i++) begin
        vd[i] <= vd[i-1];
      end
    end
  end

  // products
  always_ff @(posedge clk) begin
    m_pl    <= pd[CL-1];
    prod_cw <= cos_q * $signed({1'b0, pd[CL-1].w});
    prod_sh <= sin_q * $signed({1'b0, pd[CL-1].h});
    prod_sw <= sin_q * $signed({1'b0, pd[CL-1].w});
    prod_ch <= cos_q * $signed({1'b0, pd[CL-1].h});
  end

  // corner sums
  always_comb begin
    bx = svq_pkg::P_W'(m_pl.cxq) <<< 30;
    by = svq_pkg::P_W'(m_pl.cyq) <<< 30;
    ea = svq_pkg::P_W'(prod_cw);
    eb = svq_pkg::P_W'(prod_sh);
    ec = svq_pkg::P_W'(prod_sw);
    ed = svq_pkg::P_W'(prod_ch);
  end

  always_ff @(posedge clk) begin
    s_pl  <= m_pl;
    px[0] <= bx - ea + eb;
    px[1] <= bx + ea + eb;
    px[2] <= bx - ea - eb;
    px[3] <= bx + ea - eb;
    py[0] <= by - ec - ed;
    py[1] <= by + ec - ed;
    py[2] <= by - ec + ed;
    py[3] <= by + ec + ed;
  end

  // round, offset into divider range
  always_comb begin
    offx = $signed((svq_pkg::P_W'(viewport_w) << (svq_pkg::VP_SHIFT + 14)) +
                   (svq_pkg::P_W'(viewport_w) << (svq_pkg::VP_SHIFT - 1)));
    offy = $signed((svq_pkg::P_W'(viewport_h) << (svq_pkg::VP_SHIFT + 14)) -
                   (svq_pkg::P_W'(viewport_h) << (svq_pkg::VP_SHIFT - 1)));
  end

  always_ff @(posedge clk) begin
    n_pl <= s_pl;
    for (int k = 0; k < 4; k++) begin
      nx[k] <= svq_pkg::NUM_W'((px[k] + offx) >>> svq_pkg::VP_SHIFT);
      ny[k] <= svq_pkg::NUM_W'((py[k] + offy) >>> svq_pkg::VP_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
      vs <= 1'b0;
      vn <= 1'b0;
    end else begin
      vm <= vd[CL-1];
      vs <= vm;
      vn <= vs;
    end
  end

  // dividers
  for (genvar k = 0; k < 4; k++) begin : g_corner
    svq_div u_div_x (
      .clk (clk),
      .num (nx[k]),
      .den (viewport_w),
      .quo (qx[k])
    );
    svq_div u_div_y (
      .clk (clk),
      .num (ny[k]),
      .den (viewport_h),
      .quo (qy[k])
    );
  end

  svq_div u_div_u0 (
    .clk (clk),
    .num ($signed(svq_pkg::NUM_W'(n_pl.tu0))),
    .den (texture_w),
    .quo (qu0)
  );

  svq_div u_div_u1 (
    .clk (clk),
    .num ($signed(svq_pkg::NUM_W'(n_pl.tu1))),
    .den (texture_w),
    .quo (qu1)
  );

  svq_div u_div_v0 (
    .clk (clk),
    .num ($signed(svq_pkg::NUM_W'(n_pl.tv0))),
    .den (texture_h),
    .quo (qv0)
  );

  svq_div u_div_v1 (
    .clk (clk),
    .num ($signed(svq_pkg::NUM_W'(n_pl.tv1))),
    .den (texture_h),
    .quo (qv1)
  );

  always_ff @(posedge clk) begin
    rd[0] <= n_pl.rgba;
    for (int i = 1; i < DL; i++) begin
      rd[i] <= rd[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DL; i++) begin
        rv[i] <= 1'b0;
      end
    end else begin
      rv[0] <= vn;
      for (int i = 1; i < DL; i++) begin
        rv[i] <= rv[i-1];
      end
    end
  end

  assign load = rv[DL-1];

  // vertex hold and serializer
  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < 4; k++) begin
        hx[k] <= qx[k] ^ svq_pkg::NDC_X_FLIP;
        hy[k] <= qy[k] ^ svq_pkg::NDC_Y_FLIP;
      end
      hu0   <= qu0;
      hu1   <= qu1;
      hv0   <= qv0;
      hv1   <= qv1;
      hrgba <= rd[DL-1];
    end
  end

  always_comb begin
    corner          = svq_pkg::corner_of(idx);
    cur.ndc_x       = $signed(hx[corner]);
    cur.ndc_y       = $signed(hy[corner]);
    cur.vertex_rgba = hrgba;
    cur.tex_u       = corner[0] ? hu1 : hu0;
    cur.tex_v       = corner[1] ? hv1 : hv0;
    cur.last_vertex = (idx == svq_pkg::LAST_IDX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      idx           <= '0;
      vertex_strobe <= 1'b0;
    end else begin
      vertex_strobe <= active;
      if (load) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (active) begin
        idx <= idx + 3'd1;
        if (idx == svq_pkg::LAST_IDX) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      vertex <= cur;
    end
  end

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after a sprite transfer");

  a_load_spacing: assert property (@(posedge clk) disable iff (rst)
    load |-> (!active || idx == svq_pkg::LAST_IDX))
    else $error("new sprite reached the serializer mid-sequence");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (vertex_strobe && !vertex.last_vertex) |=> vertex_strobe)
    else $error("vertex sequence broken before last vertex");

  a_last_after_run: assert property (@(posedge clk) disable iff (rst)
    (vertex_strobe && vertex.last_vertex) |-> $past(vertex_strobe, 5))
    else $error("last vertex without five vertices before it");

endmodule

[hw/rtl/svq_cordic.sv]
// Pipelined CORDIC: cos and sin in signed Q3.30 (34 bits with sign) of a fraction-of-turn angle.
// Two rotations per stage plus a quadrant stage. Depends on svq_pkg.
module svq_cordic (
  input  logic                          clk,
  input  logic [15:0]                   turn,
  output logic signed [svq_pkg::CW-1:0] cos_q,
  output logic signed [svq_pkg::CW-1:0] sin_q
);

  typedef struct packed {
    logic signed [svq_pkg::CW-1:0] x;
    logic signed [svq_pkg::CW-1:0] y;
    logic signed [svq_pkg::ZW-1:0] z;
  } cvec_t;

  localparam int LAST = svq_pkg::CORDIC_STAGES - 1;

  function automatic cvec_t rotate_step(cvec_t v, int unsigned i);
    cvec_t r;
    logic signed [svq_pkg::CW-1:0] xs;
    logic signed [svq_pkg::CW-1:0] ys;
    logic signed [svq_pkg::ZW-1:0] a;
    xs = v.x >>> i;
    ys = v.y >>> i;
    a  = $signed({2'b00, svq_pkg::ATAN_TURN[i]});
    if (!v.z[svq_pkg::ZW-1]) begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - a;
    end else begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + a;
    end
    return r;
  endfunction

  logic [31:0] angle;
  cvec_t       entry;
  cvec_t       stg  [svq_pkg::CORDIC_STAGES];
  logic [1:0]  quad [svq_pkg::CORDIC_STAGES];
  logic        zero [svq_pkg::CORDIC_STAGES];

  logic signed [svq_pkg::CW-1:0] fx;
  logic signed [svq_pkg::CW-1:0] fy;

  assign angle   = 32'(turn) << (32 - svq_pkg::ANGLE_BITS);
  assign entry.x = svq_pkg::CORDIC_GAIN_INV;
  assign entry.y = '0;
  assign entry.z = $signed({2'b00, angle[29:0]});

  for (genvar g = 0; g < svq_pkg::CORDIC_STAGES; g++) begin : g_stage
    cvec_t      src;
    logic [1:0] qsrc;
    logic       zsrc;
    if (g == 0) begin : g_first
      assign src  = entry;
      assign qsrc = angle[31:30];
      assign zsrc = (angle[29:0] == 30'd0);
    end else begin : g_next
      assign src  = stg[g-1];
      assign qsrc = quad[g-1];
      assign zsrc = zero[g-1];
    end
    always_ff @(posedge clk) begin
      stg[g]  <= rotate_step(rotate_step(src, 2 * g), 2 * g + 1);
      quad[g] <= qsrc;
      zero[g] <= zsrc;
    end
  end

  always_comb begin
    fx = zero[LAST] ? svq_pkg::ONE_Q30 : stg[LAST].x;
    fy = zero[LAST] ? '0 : stg[LAST].y;
  end

  always_ff @(posedge clk) begin
    unique case (quad[LAST])
      2'd0: begin
        cos_q <= fx;
        sin_q <= fy;
      end
      2'd1: begin
        cos_q <= -fy;
        sin_q <= fx;
      end
      2'd2: begin
        cos_q <= -fx;
        sin_q <= -fy;
      end
      default: begin
        cos_q <= fy;
        sin_q <= -fx;
      end
    endcase
  end

endmodule

[hw/rtl/svq_div.sv]
// Pipelined restoring divider with a 16-bit saturating quotient.
// Entry stage classifies range, then two quotient bits per stage. Depends on svq_pkg.
module svq_div (
  input  logic                             clk,
  input  logic signed [svq_pkg::NUM_W-1:0] num,
  input  logic [svq_pkg::DEN_W-1:0]        den,
  output logic [svq_pkg::QW-1:0]           quo
);

  localparam int RW = svq_pkg::DEN_W + svq_pkg::QW;

  typedef struct packed {
    logic                    lo;
    logic                    hi;
    logic [RW-1:0]           rem;
    logic [svq_pkg::QW-1:0]  q;
  } dstage_t;

  function automatic dstage_t div_step(dstage_t s, logic [svq_pkg::DEN_W-1:0] d,
                                       int unsigned k);
    dstage_t       r;
    logic [RW-1:0] dk;
    r  = s;
    dk = RW'(d) << k;
    if (s.rem >= dk) begin
      r.rem  = s.rem - dk;
      r.q[k] = 1'b1;
    end
    return r;
  endfunction

  dstage_t stg [svq_pkg::DIV_STAGES+1];

  always_ff @(posedge clk) begin
    stg[0].lo  <= num[svq_pkg::NUM_W-1];
    stg[0].hi  <= !num[svq_pkg::NUM_W-1] &&
                  (num[svq_pkg::NUM_W-2:0] >=
                   (svq_pkg::NUM_W-1)'(RW'(den) << svq_pkg::QW));
    stg[0].rem <= num[RW-1:0];
    stg[0].q   <= '0;
  end

  for (genvar j = 1; j <= svq_pkg::DIV_STAGES; j++) begin : g_stage
    always_ff @(posedge clk) begin
      stg[j] <= div_step(div_step(stg[j-1], den, svq_pkg::QW - 2 * j + 1), den,
                         svq_pkg::QW - 2 * j);
    end
  end

  assign quo = stg[svq_pkg::DIV_STAGES].lo ? '0 :
               stg[svq_pkg::DIV_STAGES].hi ? '1 : stg[svq_pkg::DIV_STAGES].q;

endmodule

[sim/tb_sprite_quad_vertex_setup.sv]
// Self-checking testbench for sprite_quad_vertex_setup: sprites in, six vertices out.
// Holds its own fixed-point model of the vertex math; depends on svq_pkg and sprite_quad_vertex_setup.
`timescale 1ns / 1ps

module tb_sprite_quad_vertex_setup;

  localparam logic [svq_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam int SETTLE_CYCLES = 40;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  svq_pkg::sprite_t              sprite;
  logic                          vertex_strobe;
  svq_pkg::vertex_t              vertex;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [svq_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [svq_pkg::DEN_W-1:0]     cfg_data;

  svq_pkg::vertex_t vertex_queue[$];
  logic [13:0]      vp_w, vp_h, tx_w, tx_h;
  int               errors;
  int               sprites_sent;
  int               vertices_seen;
  int               cfg_writes;
  int               max_gap;

  sprite_quad_vertex_setup DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sprite(sprite),
    .vertex_strobe(vertex_strobe), .vertex(vertex), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [15:0] sat16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [15:0] tex_coord(longint s, logic [13:0] size);
    longint d;
    longint q;
    d = longint'((size == 0) ? 14'd1 : size) << svq_pkg::COORD_FRAC_BITS;
    q = ((s << 14) * 2 + d) / (2 * d);
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  task automatic rotation(input logic [15:0] turn, output longint c, output longint s);
    logic [31:0] a;
    longint x, y, z, t, xs, ys;
    a = {turn, 16'h0000};
    z = longint'(a[29:0]);
    x = longint'(svq_pkg::CORDIC_GAIN_INV);
    y = 0;
    if (z == 0) begin
      x = longint'(svq_pkg::ONE_Q30);
    end else begin
      for (int i = 0; i < svq_pkg::CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - longint'(svq_pkg::ATAN_TURN[i]);
        end else begin
          x = x + ys; y = y - xs; z = z + longint'(svq_pkg::ATAN_TURN[i]);
        end
      end
    end
    case (a[31:30])
      2'd1: begin t = x; x = -y; y = t; end
      2'd2: begin x = -x; y = -y; end
      2'd3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    c = x;
    s = y;
  endtask

  task automatic predict_vertices(input svq_pkg::sprite_t sp);
    longint c, s, dx, dy, w, h, cxq, cyq, dvx, dvy, ox, oy, px, py;
    logic [15:0] nx[4], ny[4];
    logic [15:0] u0, u1, v0, v1;
    logic [1:0] cr;
    svq_pkg::vertex_t v;
    dx = longint'(sp.dest_x);
    dy = longint'(sp.dest_y);
    w = longint'(sp.dest_w);
    h = longint'(sp.dest_h);
    cxq = 2 * dx + w;
    cyq = 2 * dy + h;
    dvx = longint'((vp_w == 0) ? 14'd1 : vp_w) << svq_pkg::VP_SHIFT;
    dvy = longint'((vp_h == 0) ? 14'd1 : vp_h) << svq_pkg::VP_SHIFT;
    u0 = tex_coord(longint'(sp.src_x), tx_w);
    u1 = tex_coord(longint'(sp.src_x) + longint'(sp.src_w), tx_w);
    v0 = tex_coord(longint'(sp.src_y), tx_h);
    v1 = tex_coord(longint'(sp.src_y) + longint'(sp.src_h), tx_h);
    rotation(sp.turn, c, s);
    for (int k = 0; k < 4; k++) begin
      ox = k[0] ? w : -w;
      oy = k[1] ? h : -h;
      px = cxq * longint'(svq_pkg::ONE_Q30) + c * ox - s * oy;
      py = cyq * longint'(svq_pkg::ONE_Q30) + s * ox + c * oy;
      nx[k] = sat16(floor_div(2 * px + dvx, 2 * dvx) - 16384);
      ny[k] = sat16(16384 - floor_div(2 * py + dvy, 2 * dvy));
    end
    for (int k = 0; k < svq_pkg::VERTS; k++) begin
      cr = svq_pkg::corner_of(k[2:0]);
      v.ndc_x = nx[cr];
      v.ndc_y = ny[cr];
      v.vertex_rgba = sp.tint_rgba;
      v.tex_u = cr[0] ? u1 : u0;
      v.tex_v = cr[1] ? v1 : v0;
      v.last_vertex = (k == svq_pkg::VERTS - 1);
      vertex_queue = {vertex_queue, v};
    end
  endtask

  always @(posedge clk) begin
    if (!rst && vertex_strobe) begin
      vertices_seen++;
      if (vertex_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex %h", $time, vertex);
      end else begin
        if (vertex !== vertex_queue[0]) begin
          errors++;
          $display("%0t: vertex mismatch expected %h actual %h", $time,
                   vertex_queue[0], vertex);
          if (vertex.ndc_x !== vertex_queue[0].ndc_x)
            $display("  ndc_x expected %0d actual %0d", vertex_queue[0].ndc_x, vertex.ndc_x);
          if (vertex.ndc_y !== vertex_queue[0].ndc_y)
            $display("  ndc_y expected %0d actual %0d", vertex_queue[0].ndc_y, vertex.ndc_y);
          if (vertex.vertex_rgba !== vertex_queue[0].vertex_rgba)
            $display("  rgba expected %h actual %h", vertex_queue[0].vertex_rgba,
                     vertex.vertex_rgba);
          if (vertex.tex_u !== vertex_queue[0].tex_u)
            $display("  tex_u expected %0d actual %0d", vertex_queue[0].tex_u, vertex.tex_u);
          if (vertex.tex_v !== vertex_queue[0].tex_v)
            $display("  tex_v expected %0d actual %0d", vertex_queue[0].tex_v, vertex.tex_v);
          if (vertex.last_vertex !== vertex_queue[0].last_vertex)
            $display("  last expected %b actual %b", vertex_queue[0].last_vertex,
                     vertex.last_vertex);
        end
        void'(vertex_queue.pop_front());
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (max_gap == 0 || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(5, max_gap);
  endfunction

  task automatic send_sprite(input svq_pkg::sprite_t sp, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    sprite <= sp;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_vertices(sp);
    sprites_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [svq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [svq_pkg::DEN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      svq_pkg::REG_VIEWPORT_WIDTH:  vp_w = data;
      svq_pkg::REG_VIEWPORT_HEIGHT: vp_h = data;
      svq_pkg::REG_TEXTURE_WIDTH:   tx_w = data;
      svq_pkg::REG_TEXTURE_HEIGHT:  tx_h = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_config(input logic [svq_pkg::DEN_W-1:0] a,
                            input logic [svq_pkg::DEN_W-1:0] b,
                            input logic [svq_pkg::DEN_W-1:0] c,
                            input logic [svq_pkg::DEN_W-1:0] d);
    wait_idle();
    write_reg(svq_pkg::REG_VIEWPORT_WIDTH, a);
    write_reg(svq_pkg::REG_VIEWPORT_HEIGHT, b);
    write_reg(svq_pkg::REG_TEXTURE_WIDTH, c);
    write_reg(svq_pkg::REG_TEXTURE_HEIGHT, d);
    cfg_valid <= 1'b0;
  endtask

  function automatic svq_pkg::sprite_t random_sprite(bit wide);
    svq_pkg::sprite_t sp;
    sp.dest_x = 16'($urandom);
    sp.dest_y = 16'($urandom);
    sp.dest_w = 16'($urandom);
    sp.dest_h = 16'($urandom);
    sp.tint_rgba = $urandom;
    sp.turn = 16'($urandom);
    sp.src_x = 16'($urandom);
    sp.src_y = 16'($urandom);
    sp.src_w = 16'($urandom);
    sp.src_h = 16'($urandom);
    if (!wide) begin
      sp.dest_x = $signed(16'($urandom_range(0, 20480))) - 16'sd2048;
      sp.dest_y = $signed(16'($urandom_range(0, 12800))) - 16'sd2048;
      sp.dest_w = 16'($urandom_range(0, 4096));
      sp.dest_h = 16'($urandom_range(0, 4096));
      sp.src_x = 16'($urandom_range(0, 4096));
      sp.src_y = 16'($urandom_range(0, 4096));
      sp.src_w = 16'($urandom_range(0, 4096));
      sp.src_h = 16'($urandom_range(0, 4096));
    end
    return sp;
  endfunction

  function automatic svq_pkg::sprite_t make_sprite(logic [15:0] x, logic [15:0] y,
                                                   logic [15:0] w, logic [15:0] h,
                                                   logic [15:0] turn, logic [15:0] sv);
    svq_pkg::sprite_t sp;
    sp = '{dest_x: x, dest_y: y, dest_w: w, dest_h: h, tint_rgba: $urandom, turn: turn,
           src_x: sv, src_y: sv, src_w: sv, src_h: sv};
    return sp;
  endfunction

  task automatic test_directed();
    logic [15:0] turns[8];
    turns = '{16'h0000, 16'h0001, 16'h2000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
              16'h1234};
    max_gap = 0;
    send_sprite(make_sprite(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 0);
    send_sprite(make_sprite(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
    send_sprite(make_sprite(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h0000), 0);
    send_sprite(make_sprite(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000, 16'hFFFF), 0);
    foreach (turns[i])
      send_sprite(make_sprite(16'd4000, 16'd3000, 16'd1600, 16'd800, turns[i], 16'd512), 1);
    send_sprite(make_sprite(16'd10240, 16'd5760, 16'd0, 16'd0, 16'h3000, 16'd4096), 0);
    send_sprite(make_sprite(16'd0, 16'd0, 16'd20480, 16'd11520, 16'h0000, 16'd4096), 3);
  endtask

  task automatic test_config_extremes();
    set_config(14'd0, 14'd0, 14'd0, 14'd0);
    repeat (3) send_sprite(random_sprite(0), 0);
    send_sprite(make_sprite(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h6000, 16'hFFFF), 0);
    set_config(14'd8192, 14'd8192, 14'd8192, 14'd8192);
    repeat (3) send_sprite(random_sprite(1), 0);
    set_config(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
    repeat (3) send_sprite(random_sprite(1), 0);
    set_config(14'd1, 14'd1, 14'd1, 14'd1);
    repeat (3) send_sprite(random_sprite(0), 0);
    wait_idle();
    write_reg(REG_UNUSED, 14'h2AAA);
    write_reg(REG_UNUSED, 14'h1555);
    cfg_valid <= 1'b0;
    repeat (2) send_sprite(random_sprite(0), 0);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 5; phase++) begin
      set_config(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
                 14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)));
      if (phase == 0) set_config(14'd1280, 14'd720, 14'd256, 14'd256);
      max_gap = (phase == 2) ? 0 : 30;
      for (int n = 0; n < 80; n++) begin
        if (n == 40 && phase == 3) wait_idle();
        send_sprite(random_sprite($urandom_range(0, 3) == 0), pick_gap());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start <= 1'b0;
    sprite <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= svq_pkg::REG_VIEWPORT_WIDTH;
    cfg_data <= '0;
    errors = 0;
    sprites_sent = 0;
    vertices_seen = 0;
    cfg_writes = 0;
    max_gap = 0;
    vp_w = svq_pkg::VIEWPORT_WIDTH_RST;
    vp_h = svq_pkg::VIEWPORT_HEIGHT_RST;
    tx_w = svq_pkg::TEXTURE_WIDTH_RST;
    tx_h = svq_pkg::TEXTURE_HEIGHT_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_config_extremes();
    test_random();

    start <= 1'b0;
    for (int i = 0; i < 5000 && vertex_queue.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (vertex_queue.size() != 0) begin
      errors++;
      $display("%0t: %0d expected vertices never arrived", $time, vertex_queue.size());
    end
    $display("covered %0d sprites, %0d vertices, %0d register writes, %0d errors",
             sprites_sent, vertices_seen, cfg_writes, errors);
    $display("sizes: reset, zero, one, 8192, 16383 and random; unused register index");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/svq_pkg.sv
hw/rtl/svq_cordic.sv
hw/rtl/svq_div.sv
hw/rtl/sprite_quad_vertex_setup.sv
sim/tb_sprite_quad_vertex_setup.sv
